### rtl/cbd_pkg.sv
// Package: constants, payload types and codes for the correlated bond dilution block.
`timescale 1ns / 1ps
`default_nettype none
package cbd_pkg;
  localparam int MAX_EDGES = 4096;
  localparam int MAX_NODES = 4096;
  localparam int EI_W      = $clog2(MAX_EDGES);
  localparam int NI_W      = $clog2(MAX_NODES);
  localparam int CNT_W     = EI_W + 1;
  localparam int NCELL     = 8;
  localparam int REM_W     = 5;

  localparam logic [2:0] ST_STORED   = 3'd0;
  localparam logic [2:0] ST_REJECTED = 3'd1;
  localparam logic [2:0] ST_ACCEPTED = 3'd2;
  localparam logic [2:0] ST_IGNORED  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  localparam logic [1:0] CFG_BASE    = 2'd0;
  localparam logic [1:0] CFG_PORTION = 2'd1;
  localparam logic [1:0] CFG_MAXNB   = 2'd2;

  typedef struct packed {
    logic        func;
    logic [11:0] end_a;
    logic [11:0] end_b;
    logic        last;
    logic [11:0] pick;
    logic [31:0] draw;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] edge_num;
    logic [12:0] kept_total;
    logic        finished;
  } result_t;

  typedef struct packed {
    logic             valid;
    logic [31:0]      r;
    logic [REM_W-1:0] rem;
  } tok_t;
endpackage
`default_nettype wire

### rtl/cbd_if.sv
// Valid/ready channel interfaces for items and results.
`timescale 1ns / 1ps
`default_nettype none
interface cbd_item_if import cbd_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cbd_result_if import cbd_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/cbd_pow_cell.sv
// One cell of the power chain: optional truncating Q0.32 multiply, then hand-off.
`timescale 1ns / 1ps
`default_nettype none
module cbd_pow_cell import cbd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire tok_t        tok_i,
  input  wire logic [31:0] base_i,
  output tok_t             tok_o
);
  logic [63:0] prod;
  logic        v_q;
  logic [31:0] r_q;
  logic [REM_W-1:0] rem_q;

  assign prod = 64'(tok_i.r) * 64'(base_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_i.rem != '0) begin
      r_q   <= prod[63:32];
      rem_q <= tok_i.rem - REM_W'(1);
    end else begin
      r_q   <= tok_i.r;
      rem_q <= tok_i.rem;
    end
  end

  assign tok_o = '{valid: v_q, r: r_q, rem: rem_q};
endmodule
`default_nettype wire

### rtl/correlated_bond_dilution.sv
// Top level: edge store, candidate pool, valence store, control and power chain.
// A trial that is not ignored reads pool, ends and valences, then passes the power chain
//   (not at all when the exponent is 0 or less or the base is 1.0 or more, else
//   ceil((exponent-1)/8) times, at least once); acceptance then closes up the pool.
// One item in work at a time; a new item is taken while the last result waits.
// Reset: async active low; the valence store is then cleared, and cleared again
//   on the first load of a new set, with no item taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module correlated_bond_dilution import cbd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  cbd_item_if.sink         item_i,
  cbd_result_if.source     result_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [32:0] cfg_data_i
);
  typedef enum logic [12:0] {
    S_CLEAR = 13'h0001, S_IDLE  = 13'h0002, S_DEC   = 13'h0004, S_LOAD  = 13'h0008,
    S_POOL  = 13'h0010, S_ENDS  = 13'h0020, S_VAL   = 13'h0040, S_POW   = 13'h0080,
    S_BUMPA = 13'h0100, S_BUMPB = 13'h0200, S_SHIFT = 13'h0400, S_RESP  = 13'h0800,
    S_DRAIN = 13'h1000
  } state_e;

  function automatic logic [7:0] sat_add(input logic [7:0] v, input logic two);
    logic [8:0] s;
    s = 9'(v) + (two ? 9'd2 : 9'd1);
    return (s > 9'd255) ? 8'd255 : s[7:0];
  endfunction

  state_e state_q, state_d;

  logic [32:0] base_q;
  logic [16:0] portion_q;
  logic [4:0]  mn_q;

  item_t item_q;
  logic [CNT_W-1:0] pool_size_q, edge_total_q, target_q, kept_q;
  logic             closed_q, pend_q;
  logic [NI_W-1:0]  clr_q;
  logic [CNT_W-1:0] ptr_q;
  logic [EI_W-1:0]  wptr_q;
  logic             wpend_q;
  logic [EI_W-1:0]  e_q;
  logic [NI_W-1:0]  na_q, nb_q;
  logic [7:0]       va_q, vb_q;
  logic [2:0]       st_q;
  logic [EI_W-1:0]  idx_q;
  logic             out_valid_q;
  result_t          out_q;

  // memories
  logic [23:0]     ends_mem [MAX_EDGES];
  logic [EI_W-1:0] pool_mem [MAX_EDGES];
  logic [7:0]      val_mem  [MAX_NODES];
  logic [23:0]     ends_rd;
  logic [EI_W-1:0] pool_rd;
  logic [7:0]      va_rd, vb_rd;

  logic            ends_we, pool_we, val_we;
  logic [EI_W-1:0] ends_wa, pool_wa, pool_ra, ends_ra;
  logic [23:0]     ends_wd;
  logic [EI_W-1:0] pool_wd;
  logic [NI_W-1:0] val_wa, val_ra0, val_ra1;
  logic [7:0]      val_wd;

  always_ff @(posedge clk_i) begin
    if (ends_we) ends_mem[ends_wa] <= ends_wd;
    ends_rd <= ends_mem[ends_ra];
  end
  always_ff @(posedge clk_i) begin
    if (pool_we) pool_mem[pool_wa] <= pool_wd;
    pool_rd <= pool_mem[pool_ra];
  end
  always_ff @(posedge clk_i) begin
    if (val_we) val_mem[val_wa] <= val_wd;
    va_rd <= val_mem[val_ra0];
    vb_rd <= val_mem[val_ra1];
  end

  // power chain
  tok_t            tok [NCELL+1];
  tok_t            start_tok;
  logic            pow_start, pow_done;
  logic [NCELL-1:0] cell_v;

  assign pow_done = tok[NCELL].valid && (tok[NCELL].rem == '0);
  always_comb begin
    if (pow_start) begin
      tok[0] = start_tok;
    end else if (tok[NCELL].valid && tok[NCELL].rem != '0) begin
      tok[0] = tok[NCELL];
    end else begin
      tok[0] = '0;
    end
  end

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    cbd_pow_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok[i]),
      .base_i (base_q[31:0]),
      .tok_o  (tok[i+1])
    );
    assign cell_v[i] = tok[i+1].valid;
  end

  // exponent
  logic [8:0] vsum;
  logic       expo_le0;
  logic [9:0] rem_full;
  assign vsum     = 9'(va_rd) + 9'(vb_rd);
  assign expo_le0 = 9'(mn_q) <= vsum;
  assign rem_full = 10'(mn_q) - 10'(vsum) - 10'd1;
  assign start_tok = '{valid: 1'b1, r: base_q[31:0], rem: rem_full[REM_W-1:0]};

  logic [16:0] por;
  logic [CNT_W-1:0] et_new;
  logic [29:0] tprod;
  assign por    = (portion_q > 17'd65536) ? 17'd65536 : portion_q;
  assign tprod  = 30'(por) * 30'(et_new);

  logic full;
  assign full = edge_total_q == CNT_W'(MAX_EDGES);
  assign et_new = full ? edge_total_q : edge_total_q + CNT_W'(1);

  logic shift_issue;
  assign shift_issue = (ptr_q + CNT_W'(1)) < pool_size_q;

  assign item_i.ready    = (state_q == S_IDLE);
  assign result_o.valid  = out_valid_q;
  assign result_o.data   = out_q;

  always_comb begin
    ends_we = 1'b0; ends_wa = edge_total_q[EI_W-1:0];
    ends_wd = {item_q.end_a, item_q.end_b};
    ends_ra = pool_rd;
    pool_we = 1'b0; pool_wa = pool_size_q[EI_W-1:0]; pool_wd = edge_total_q[EI_W-1:0];
    pool_ra = (state_q == S_DEC) ? item_q.pick : EI_W'(ptr_q + CNT_W'(1));
    val_we  = 1'b0; val_wa = clr_q; val_wd = '0;
    val_ra0 = ends_rd[23:12];
    val_ra1 = ends_rd[11:0];
    pow_start = 1'b0;
    unique case (state_q)
      S_CLEAR: val_we = 1'b1;
      S_LOAD: begin
        ends_we = !full;
        pool_we = !full;
      end
      S_VAL: pow_start = !expo_le0 && !base_q[32];
      S_BUMPA: begin
        val_we = 1'b1; val_wa = na_q; val_wd = sat_add(va_q, na_q == nb_q);
      end
      S_BUMPB: begin
        val_we = na_q != nb_q; val_wa = nb_q; val_wd = sat_add(vb_q, 1'b0);
      end
      S_SHIFT, S_DRAIN: begin
        pool_we = wpend_q; pool_wa = wptr_q; pool_wd = pool_rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= 33'h1_0000_0000;
      portion_q <= 17'd65536;
      mn_q      <= 5'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BASE:    base_q    <= cfg_data_i;
        CFG_PORTION: portion_q <= cfg_data_i[16:0];
        CFG_MAXNB:   mn_q      <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) item_q <= item_i.data;
    if (state_q == S_POOL) e_q <= pool_rd;
    if (state_q == S_ENDS) begin
      na_q <= ends_rd[23:12];
      nb_q <= ends_rd[11:0];
    end
    if (state_q == S_VAL) begin
      va_q <= va_rd;
      vb_q <= vb_rd;
    end
    wptr_q <= ptr_q[EI_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      pool_size_q <= '0; edge_total_q <= '0; target_q <= '0; kept_q <= '0;
      closed_q <= 1'b0; pend_q <= 1'b0; clr_q <= '0; ptr_q <= '0; wpend_q <= 1'b0;
      st_q <= ST_IGNORED; idx_q <= '0; out_valid_q <= 1'b0; out_q <= '0;
    end else begin
      if (state_q == S_RESP && (!out_valid_q || result_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (result_o.valid && result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      wpend_q <= (state_q == S_SHIFT) && shift_issue;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + NI_W'(1);
          if (clr_q == '1) begin
            pend_q  <= 1'b0;
            state_q <= pend_q ? S_LOAD : S_IDLE;
          end
        end
        S_IDLE: if (item_i.valid) state_q <= S_DEC;
        S_DEC: begin
          if (!item_q.func) begin
            if (closed_q) begin
              pool_size_q <= '0; edge_total_q <= '0; target_q <= '0; kept_q <= '0;
              closed_q <= 1'b0; pend_q <= 1'b1; clr_q <= '0;
              state_q <= S_CLEAR;
            end else begin
              state_q <= S_LOAD;
            end
          end else if (!closed_q || kept_q >= target_q ||
                       CNT_W'(item_q.pick) >= pool_size_q) begin
            st_q <= ST_IGNORED; idx_q <= '0; state_q <= S_RESP;
          end else begin
            state_q <= S_POOL;
          end
        end
        S_LOAD: begin
          if (full) begin
            st_q <= ST_FULL; idx_q <= '0;
          end else begin
            st_q <= ST_STORED; idx_q <= edge_total_q[EI_W-1:0];
            edge_total_q <= et_new;
            pool_size_q  <= pool_size_q + CNT_W'(1);
          end
          if (item_q.last) begin
            target_q <= tprod[CNT_W+15:16];
            closed_q <= 1'b1;
          end
          state_q <= S_RESP;
        end
        S_POOL: state_q <= S_ENDS;
        S_ENDS: state_q <= S_VAL;
        S_VAL: begin
          if (expo_le0 || base_q[32]) begin
            state_q <= S_BUMPA;
          end else begin
            state_q <= S_POW;
          end
        end
        S_POW: begin
          if (pow_done) begin
            if (tok[NCELL].r > item_q.draw) begin
              state_q <= S_BUMPA;
            end else begin
              st_q <= ST_REJECTED; idx_q <= e_q; state_q <= S_RESP;
            end
          end
        end
        S_BUMPA: begin
          kept_q  <= kept_q + CNT_W'(1);
          state_q <= S_BUMPB;
        end
        S_BUMPB: begin
          ptr_q   <= CNT_W'(item_q.pick);
          state_q <= S_SHIFT;
        end
        S_SHIFT: begin
          if (shift_issue) begin
            ptr_q   <= ptr_q + CNT_W'(1);
          end else begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          pool_size_q <= pool_size_q - CNT_W'(1);
          st_q <= ST_ACCEPTED; idx_q <= e_q;
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_q || result_o.ready) begin
            out_q <= '{status: st_q, edge_num: idx_q, kept_total: kept_q,
                       finished: closed_q && (kept_q >= target_q)};
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) pool_size_q <= edge_total_q)
    else $error("pool larger than edge set");
  assert property (@(posedge clk_i) disable iff (!rst_ni) kept_q <= target_q)
    else $error("kept count passed target");
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(cell_v))
    else $error("more than one token in power chain");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (ptr_q < pool_size_q))
    else $error("close-up pointer outside pool");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |=> (pool_size_q == $past(pool_size_q) - CNT_W'(1)))
    else $error("pool did not shrink on accept");
endmodule
`default_nettype wire

### tb/tb_correlated_bond_dilution.sv
// Testbench for the correlated bond dilution block: loads edge sets, runs trials, checks results.
`timescale 1ns / 1ps
`default_nettype none
module tb_correlated_bond_dilution import cbd_pkg::*; ();

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [32:0] cfg_data_i;

  cbd_item_if   item_ch ();
  cbd_result_if res_ch ();

  correlated_bond_dilution DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_ch.sink),
    .result_o   (res_ch.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b1; #6;
    clk_i = 1'b0; #6;
  end

  // predictor state
  logic [23:0] pr_ends [MAX_EDGES];
  logic [11:0] pr_pool [MAX_EDGES];
  logic [7:0]  pr_val  [MAX_NODES];
  int unsigned pr_pool_n, pr_edges, pr_target, pr_kept;
  bit          pr_closed;
  logic [32:0] pr_base;
  logic [16:0] pr_portion;
  logic [4:0]  pr_maxnb;

  result_t     expected_q [$];
  int          send_idle_pct, recv_idle_pct;
  int          mismatches = 0;
  longint      cycle_cnt = 0;
  bit          stim_done;

  function automatic result_t make_result(logic [2:0] st, int unsigned idx);
    result_t r;
    r.status     = st;
    r.edge_num   = idx[11:0];
    r.kept_total = pr_kept[12:0];
    r.finished   = pr_closed && (pr_kept >= pr_target);
    return r;
  endfunction

  function automatic result_t predict_dilution(item_t it);
    int unsigned e, na, nb, por;
    int          expo;
    logic [63:0] pw;
    bit          acc;
    if (!it.func) begin
      logic [2:0]  st;
      int unsigned idx;
      st = ST_FULL;
      idx = 0;
      if (pr_closed) begin
        foreach (pr_val[i]) pr_val[i] = '0;
        pr_pool_n = 0; pr_edges = 0; pr_target = 0; pr_kept = 0; pr_closed = 0;
      end
      if (pr_edges < MAX_EDGES) begin
        pr_ends[pr_edges] = {it.end_a, it.end_b};
        pr_pool[pr_pool_n] = pr_edges[11:0];
        pr_pool_n++;
        idx = pr_edges;
        pr_edges++;
        st = ST_STORED;
      end
      if (it.last) begin
        por = (pr_portion > 17'd65536) ? 65536 : pr_portion;
        pr_target = 32'((64'(por) * pr_edges) >> 16);
        pr_closed = 1;
      end
      return make_result(st, idx);
    end
    if (!pr_closed || pr_kept >= pr_target || it.pick >= pr_pool_n)
      return make_result(ST_IGNORED, 0);
    e  = pr_pool[it.pick];
    na = pr_ends[e][23:12];
    nb = pr_ends[e][11:0];
    expo = int'(pr_maxnb) - int'(pr_val[na]) - int'(pr_val[nb]);
    if (expo <= 0) acc = 1;
    else begin
      pw = 64'h1_0000_0000;
      if (pr_base < 33'h1_0000_0000) begin
        pw = pr_base;
        for (int k = 1; k < expo; k++) pw = (pw * pr_base) >> 32;
      end
      acc = pw > it.draw;
    end
    if (!acc) return make_result(ST_REJECTED, e);
    for (int unsigned i = it.pick; i + 1 < pr_pool_n; i++) pr_pool[i] = pr_pool[i + 1];
    pr_pool_n--;
    pr_kept++;
    if (pr_val[na] < 8'd255) pr_val[na]++;
    if (pr_val[nb] < 8'd255) pr_val[nb]++;
    return make_result(ST_ACCEPTED, e);
  endfunction

  task automatic send_item(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= it;
    @(posedge clk_i);
    while (!item_ch.ready) @(posedge clk_i);
    expected_q.insert(expected_q.size(), predict_dilution(it));
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [32:0] val);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == CFG_BASE) pr_base = val;
    else if (idx == CFG_PORTION) pr_portion = val[16:0];
    else pr_maxnb = val[4:0];
  endtask

  function automatic item_t load_item(logic [11:0] a, logic [11:0] b, logic l);
    item_t it;
    it = item_t'(70'({$urandom, $urandom, $urandom}));
    it.func = 1'b0; it.end_a = a; it.end_b = b; it.last = l;
    return it;
  endfunction

  function automatic item_t trial_item(logic [11:0] p, logic [31:0] d);
    item_t it;
    it = item_t'(70'({$urandom, $urandom, $urandom}));
    it.func = 1'b1; it.pick = p; it.draw = d;
    return it;
  endfunction

  // checker
  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", res_ch.data);
      end else begin
        result_t x;
        x = expected_q.pop_front();
        if (res_ch.data !== x) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", x, res_ch.data);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > 10000000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic test_directed();
    write_cfg(CFG_BASE, 33'h1_0000_0000);
    write_cfg(CFG_PORTION, 17'd65536);
    write_cfg(CFG_MAXNB, 5'd4);
    send_item(trial_item(12'd0, 32'd0));           // trial before close
    send_item(load_item(12'd0, 12'd4095, 1'b0));
    send_item(load_item(12'd4095, 12'd4095, 1'b0)); // same endpoints
    send_item(load_item(12'd7, 12'd0, 1'b1));
    send_item(trial_item(12'd4095, 32'hFFFF_FFFF)); // pick outside pool
    send_item(trial_item(12'd3, 32'd0));
    send_item(trial_item(12'd1, 32'hFFFF_FFFF));
    send_item(trial_item(12'd0, 32'hFFFF_FFFF));
    send_item(trial_item(12'd0, 32'd0));
    send_item(trial_item(12'd0, 32'd0));
    send_item(trial_item(12'd0, 32'd0));            // target reached
    write_cfg(CFG_BASE, 33'd0);
    write_cfg(CFG_PORTION, 17'h1FFFF);
    send_item(load_item(12'd1, 12'd2, 1'b0));       // new set
    send_item(load_item(12'd3, 12'd1, 1'b1));
    send_item(trial_item(12'd0, 32'd0));
    send_item(trial_item(12'd0, 32'd0));
    send_item(trial_item(12'd0, 32'd0));
    write_cfg(CFG_MAXNB, 5'd31);
    write_cfg(CFG_BASE, 33'h1_FFFF_FFFF);
    send_item(load_item(12'd5, 12'd5, 1'b1));
    send_item(trial_item(12'd0, 32'hFFFF_FFFF));
  endtask

  task automatic run_random_sets(int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      int ne, nt, nn;
      ne = $urandom_range(1, 24);
      nn = $urandom_range(2, 40);
      for (int i = 0; i < ne; i++) begin
        logic [11:0] a, b;
        a = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(nn - 1));
        b = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(nn - 1));
        send_item(load_item(a, b, i == ne - 1));
        sent++;
      end
      nt = $urandom_range(ne, 3 * ne);
      for (int i = 0; i < nt; i++) begin
        logic [11:0] p;
        p = ($urandom_range(15) == 0) ? 12'($urandom) : 12'($urandom_range(ne));
        send_item(trial_item(p, $urandom));
        sent++;
      end
      if ($urandom_range(7) == 0) begin
        drain();
        send_item(trial_item(12'($urandom), $urandom));
        sent++;
      end
    end
  endtask

  task automatic test_random();
    logic [32:0] bases [4] = '{33'd0, 33'h0_C000_0000, 33'h0_FFFF_FFFF, 33'h1_0000_0000};
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 0) begin send_idle_pct = 11; recv_idle_pct = 79; end
      else if (ph == 1) begin send_idle_pct = 79; recv_idle_pct = 11; end
      else begin send_idle_pct = 0; recv_idle_pct = 0; end
      for (int k = 0; k < 4; k++) begin
        write_cfg(CFG_BASE, ($urandom_range(1) == 0) ? bases[k] : {1'b0, $urandom});
        write_cfg(CFG_PORTION, (k == 0) ? 17'd65536 : $urandom_range(65536));
        write_cfg(CFG_MAXNB, (k == 1) ? 5'd1 : (k == 2) ? 5'd16 : $urandom_range(1, 31));
        run_random_sets(95);
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = CFG_BASE; cfg_data_i = '0;
    item_ch.valid = 1'b0; item_ch.data = '0;
    send_idle_pct = 0; recv_idle_pct = 0;
    pr_pool_n = 0; pr_edges = 0; pr_target = 0; pr_kept = 0; pr_closed = 0;
    foreach (pr_val[i]) pr_val[i] = '0;
    pr_base = 33'h1_0000_0000; pr_portion = 17'd65536; pr_maxnb = 5'd4;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    send_idle_pct = 0; recv_idle_pct = 0;
    drain();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire

### correlated_bond_dilution.f
rtl/cbd_pkg.sv
rtl/cbd_if.sv
rtl/cbd_pow_cell.sv
rtl/correlated_bond_dilution.sv
tb/tb_correlated_bond_dilution.sv
